// ===== src/ktt_pkg.sv =====
// shared types, widths and codes of the keyframe timeline tracker
package ktt_pkg;

  localparam int DEF_MAX_FRAMES = 64;
  localparam int DEF_TIME_BITS  = 32;

  localparam int REQ_W      = 2;
  localparam int IDX_W      = 6;
  localparam int END_W      = 32;
  localparam int DELTA_W    = 32;
  localparam int PLAY_W     = 16;
  localparam int FCNT_W     = 7;
  localparam int PROG_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD    = 2'd0,
    REQ_ADVANCE = 2'd1,
    REQ_RESTART = 2'd2,
    REQ_NOP     = 2'd3
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_COUNT = 1'b0,
    CFG_PLAY_TARGET = 1'b1
  } cfg_reg_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_LAST_RD,
    S_LAST_CHK,
    S_DIV,
    S_WRAP,
    S_FS_RD,
    S_FS_CHK,
    S_B0_RD,
    S_B0_CHK,
    S_BS_RD,
    S_BS_CHK,
    S_P_LAST_RD,
    S_P_LAST_CHK,
    S_P_HI_RD,
    S_P_HI_CHK,
    S_P_LO_RD,
    S_P_LO_CHK,
    S_P_CALC,
    S_P_DIV,
    S_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_EXEC,
    OP_DIV_WRAP,
    OP_APPLY_WRAP,
    OP_FP_INC,
    OP_FP_DEC,
    OP_FP_ZERO,
    OP_CAP_HI,
    OP_CAP_LO,
    OP_PROG_ZERO,
    OP_PROG_SAT,
    OP_DIV_PROG,
    OP_PROG_Q,
    OP_OUT
  } op_e;

  typedef enum logic [1:0] {
    A_ZERO,
    A_LAST,
    A_FP,
    A_FPM1
  } addr_sel_e;

  typedef struct packed {
    op_e       op;
    addr_sel_e addr;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    req_e req;
    logic go_move;
    logic rd_zero;
    logic wrap;
    logic div_busy;
    logic hit_end;
    logic back;
    logic gt_rd;
    logic fp_lt_last;
    logic fp_zero;
    logic num_le0;
    logic prog_sat;
    logic out_free;
  } status_t;

endpackage

// ===== src/ktt_in_if.sv =====
// input channel of the timeline tracker
interface ktt_in_if;
  logic                                valid;
  logic                                ready;
  logic [ktt_pkg::REQ_W-1:0]           req_type;
  logic [ktt_pkg::IDX_W-1:0]           frame_index;
  logic [ktt_pkg::END_W-1:0]           frame_end_time;
  logic signed [ktt_pkg::DELTA_W-1:0]  time_delta;
  logic [ktt_pkg::PLAY_W-1:0]          start_play_count;
  logic                                loop_forever;

  modport source (output valid, req_type, frame_index, frame_end_time, time_delta,
                  start_play_count, loop_forever, input ready);
  modport sink (input valid, req_type, frame_index, frame_end_time, time_delta,
                start_play_count, loop_forever, output ready);
endinterface

// ===== src/ktt_out_if.sv =====
// result channel of the timeline tracker
interface ktt_out_if;
  logic                         valid;
  logic                         ready;
  logic [ktt_pkg::IDX_W-1:0]    current_frame;
  logic [ktt_pkg::PLAY_W-1:0]   play_count;
  logic [ktt_pkg::PROG_W-1:0]   frame_progress;
  logic                         finished;

  modport source (output valid, current_frame, play_count, frame_progress, finished,
                  input ready);
  modport sink (input valid, current_frame, play_count, frame_progress, finished,
                output ready);
endinterface

// ===== src/ktt_ram.sv =====
// generic single write, single read ram with registered read
module ktt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== src/ktt_div.sv =====
// restoring divider, one quotient bit per cycle
module ktt_div #(
  parameter int DW = 48,
  parameter int VW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dvd_i,
  input  logic [VW-1:0] dvs_i,
  output logic          busy_o,
  output logic [DW-1:0] quo_o,
  output logic [VW-1:0] rem_o
);
  localparam int CW = $clog2(DW + 1);

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] dvs_q, dvs_d;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;

  always_comb begin
    trial  = {rem_q, quo_q[DW-1]};
    diff   = trial - {1'b0, dvs_q};
    ge     = trial >= {1'b0, dvs_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DW);
      quo_d  = dvd_i;
      rem_d  = '0;
      dvs_d  = dvs_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[VW-1:0] : trial[VW-1:0];
      quo_d = {quo_q[DW-2:0], ge};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule

// ===== src/ktt_ctrl.sv =====
// sequencer of the timeline tracker
module ktt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ktt_pkg::status_t st_i,
  output ktt_pkg::cmd_t    cmd_o,
  output logic             in_ready_o
);
  ktt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ktt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = ktt_pkg::OP_NONE;
    cmd_o.addr = ktt_pkg::A_ZERO;
    unique case (state_q)
      ktt_pkg::S_IDLE: begin
        if (st_i.in_valid) begin
          cmd_o.op = ktt_pkg::OP_ACCEPT;
          state_d  = ktt_pkg::S_DISPATCH;
        end
      end
      ktt_pkg::S_DISPATCH: begin
        cmd_o.op = ktt_pkg::OP_EXEC;
        if (st_i.req == ktt_pkg::REQ_ADVANCE && st_i.go_move) begin
          state_d = ktt_pkg::S_LAST_RD;
        end else begin
          state_d = ktt_pkg::S_P_LAST_RD;
        end
      end
      ktt_pkg::S_LAST_RD: begin
        cmd_o.addr = ktt_pkg::A_LAST;
        state_d    = ktt_pkg::S_LAST_CHK;
      end
      ktt_pkg::S_LAST_CHK: begin
        if (st_i.rd_zero) begin
          state_d = ktt_pkg::S_P_LAST_RD;
        end else if (st_i.wrap) begin
          cmd_o.op = ktt_pkg::OP_DIV_WRAP;
          state_d  = ktt_pkg::S_DIV;
        end else if (st_i.back) begin
          state_d = ktt_pkg::S_B0_RD;
        end else begin
          state_d = ktt_pkg::S_FS_RD;
        end
      end
      ktt_pkg::S_DIV: begin
        if (!st_i.div_busy) begin
          state_d = ktt_pkg::S_WRAP;
        end
      end
      ktt_pkg::S_WRAP: begin
        cmd_o.op = ktt_pkg::OP_APPLY_WRAP;
        if (st_i.hit_end) begin
          state_d = ktt_pkg::S_P_LAST_RD;
        end else if (st_i.back) begin
          state_d = ktt_pkg::S_B0_RD;
        end else begin
          state_d = ktt_pkg::S_FS_RD;
        end
      end
      ktt_pkg::S_FS_RD: begin
        cmd_o.addr = ktt_pkg::A_FP;
        state_d    = st_i.fp_lt_last ? ktt_pkg::S_FS_CHK : ktt_pkg::S_P_LAST_RD;
      end
      ktt_pkg::S_FS_CHK: begin
        if (st_i.gt_rd) begin
          cmd_o.op = ktt_pkg::OP_FP_INC;
          state_d  = ktt_pkg::S_FS_RD;
        end else begin
          state_d = ktt_pkg::S_P_LAST_RD;
        end
      end
      ktt_pkg::S_B0_RD: begin
        cmd_o.addr = ktt_pkg::A_ZERO;
        state_d    = ktt_pkg::S_B0_CHK;
      end
      ktt_pkg::S_B0_CHK: begin
        if (st_i.gt_rd) begin
          state_d = ktt_pkg::S_BS_RD;
        end else begin
          cmd_o.op = ktt_pkg::OP_FP_ZERO;
          state_d  = ktt_pkg::S_P_LAST_RD;
        end
      end
      ktt_pkg::S_BS_RD: begin
        cmd_o.addr = ktt_pkg::A_FPM1;
        state_d    = st_i.fp_zero ? ktt_pkg::S_P_LAST_RD : ktt_pkg::S_BS_CHK;
      end
      ktt_pkg::S_BS_CHK: begin
        if (!st_i.gt_rd) begin
          cmd_o.op = ktt_pkg::OP_FP_DEC;
          state_d  = ktt_pkg::S_BS_RD;
        end else begin
          state_d = ktt_pkg::S_P_LAST_RD;
        end
      end
      ktt_pkg::S_P_LAST_RD: begin
        cmd_o.addr = ktt_pkg::A_LAST;
        state_d    = ktt_pkg::S_P_LAST_CHK;
      end
      ktt_pkg::S_P_LAST_CHK: begin
        if (st_i.rd_zero) begin
          cmd_o.op = ktt_pkg::OP_PROG_ZERO;
          state_d  = ktt_pkg::S_OUT;
        end else begin
          state_d = ktt_pkg::S_P_HI_RD;
        end
      end
      ktt_pkg::S_P_HI_RD: begin
        cmd_o.addr = ktt_pkg::A_FP;
        state_d    = ktt_pkg::S_P_HI_CHK;
      end
      ktt_pkg::S_P_HI_CHK: begin
        cmd_o.op = ktt_pkg::OP_CAP_HI;
        state_d  = st_i.fp_zero ? ktt_pkg::S_P_CALC : ktt_pkg::S_P_LO_RD;
      end
      ktt_pkg::S_P_LO_RD: begin
        cmd_o.addr = ktt_pkg::A_FPM1;
        state_d    = ktt_pkg::S_P_LO_CHK;
      end
      ktt_pkg::S_P_LO_CHK: begin
        cmd_o.op = ktt_pkg::OP_CAP_LO;
        state_d  = ktt_pkg::S_P_CALC;
      end
      ktt_pkg::S_P_CALC: begin
        if (st_i.num_le0) begin
          cmd_o.op = ktt_pkg::OP_PROG_ZERO;
          state_d  = ktt_pkg::S_OUT;
        end else if (st_i.prog_sat) begin
          cmd_o.op = ktt_pkg::OP_PROG_SAT;
          state_d  = ktt_pkg::S_OUT;
        end else begin
          cmd_o.op = ktt_pkg::OP_DIV_PROG;
          state_d  = ktt_pkg::S_P_DIV;
        end
      end
      ktt_pkg::S_P_DIV: begin
        if (!st_i.div_busy) begin
          cmd_o.op = ktt_pkg::OP_PROG_Q;
          state_d  = ktt_pkg::S_OUT;
        end
      end
      ktt_pkg::S_OUT: begin
        if (st_i.out_free) begin
          cmd_o.op = ktt_pkg::OP_OUT;
          state_d  = ktt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ktt_pkg::S_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == ktt_pkg::S_IDLE);

  a_div_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ktt_pkg::S_DIV && st_i.div_busy) |=> (state_q == ktt_pkg::S_DIV))
    else $error("wrap division left before the divider finished");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == ktt_pkg::OP_DIV_WRAP || cmd_o.op == ktt_pkg::OP_DIV_PROG) |-> !st_i.div_busy)
    else $error("divider started while busy");

  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_i.in_valid && in_ready_o) |=> (state_q == ktt_pkg::S_DISPATCH))
    else $error("accepted transaction not dispatched");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == ktt_pkg::OP_OUT) |-> st_i.out_free)
    else $error("result register overwritten while occupied");
endmodule

// ===== src/ktt_dp.sv =====
// datapath: state registers, frame table, shared divider, result register
module ktt_dp #(
  parameter int MAX_FRAMES = ktt_pkg::DEF_MAX_FRAMES,
  parameter int TIME_BITS  = ktt_pkg::DEF_TIME_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ktt_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ktt_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  input  logic [ktt_pkg::REQ_W-1:0]           req_type_i,
  input  logic [ktt_pkg::IDX_W-1:0]           frame_index_i,
  input  logic [ktt_pkg::END_W-1:0]           frame_end_time_i,
  input  logic signed [ktt_pkg::DELTA_W-1:0]  time_delta_i,
  input  logic [ktt_pkg::PLAY_W-1:0]          start_play_count_i,
  input  logic                                loop_forever_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [ktt_pkg::IDX_W-1:0]           current_frame_o,
  output logic [ktt_pkg::PLAY_W-1:0]          play_count_o,
  output logic [ktt_pkg::PROG_W-1:0]          frame_progress_o,
  output logic                                finished_o,
  input  ktt_pkg::cmd_t                       cmd_i,
  output ktt_pkg::status_t                    st_o
);
  localparam int FW   = $clog2(MAX_FRAMES);
  localparam int AW   = TIME_BITS + 8;
  localparam int DW   = TIME_BITS + 16;
  localparam int SUMW = ((AW > ktt_pkg::DELTA_W) ? AW : ktt_pkg::DELTA_W) + 1;
  localparam int CNTW = ($clog2(MAX_FRAMES + 1) > ktt_pkg::FCNT_W) ?
                        $clog2(MAX_FRAMES + 1) : ktt_pkg::FCNT_W;
  localparam int IXW  = (FW > ktt_pkg::IDX_W) ? FW : ktt_pkg::IDX_W;
  localparam int EW   = (TIME_BITS > ktt_pkg::END_W) ? TIME_BITS : ktt_pkg::END_W;
  localparam int PW   = ktt_pkg::PLAY_W;
  localparam logic signed [AW-1:0] ANIM_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0] ANIM_MIN = {1'b1, {(AW-1){1'b0}}};

  // configuration
  logic [ktt_pkg::FCNT_W-1:0] fcount_q;
  logic [PW-1:0]              target_q;

  // accepted item
  ktt_pkg::req_e                       req_q;
  logic [ktt_pkg::IDX_W-1:0]           idx_q;
  logic [ktt_pkg::END_W-1:0]           endt_q;
  logic signed [ktt_pkg::DELTA_W-1:0]  delta_q;
  logic [PW-1:0]                       spc_q;
  logic                                loop_q;

  // timeline state
  logic signed [AW-1:0] anim_q, anim_d;
  logic [FW-1:0]        fp_q, fp_d;
  logic [PW-1:0]        plays_q, plays_d;
  logic                 endless_q, endless_d;
  logic                 back_q, back_d;
  logic                 out_valid_q, out_valid_d;

  logic [TIME_BITS-1:0] last_q, hi_q, lo_q;
  logic [ktt_pkg::PROG_W-1:0] prog_q;
  logic [ktt_pkg::IDX_W-1:0]  out_frame_q;
  logic [PW-1:0]              out_plays_q;
  logic [ktt_pkg::PROG_W-1:0] out_prog_q;
  logic                       out_fin_q;

  // frame count in use
  logic [CNTW-1:0] fc_ext, cnt, cnt_m1;
  logic [FW-1:0]   last_idx;

  always_comb begin
    fc_ext = CNTW'(fcount_q);
    if (fc_ext == '0) begin
      cnt = CNTW'(1);
    end else if (fc_ext > CNTW'(MAX_FRAMES)) begin
      cnt = CNTW'(MAX_FRAMES);
    end else begin
      cnt = fc_ext;
    end
    cnt_m1   = cnt - CNTW'(1);
    last_idx = cnt_m1[FW-1:0];
  end

  // frame table
  logic [IXW-1:0]       idx_ext;
  logic                 idx_ok;
  logic [EW-1:0]        endt_ext;
  logic                 ram_we;
  logic [FW-1:0]        raddr;
  logic [TIME_BITS-1:0] rdata;

  assign idx_ext  = IXW'(idx_q);
  assign idx_ok   = {1'b0, idx_ext} < (IXW+1)'(MAX_FRAMES);
  assign endt_ext = EW'(endt_q);
  assign ram_we   = (cmd_i.op == ktt_pkg::OP_EXEC) && (req_q == ktt_pkg::REQ_LOAD) && idx_ok;

  always_comb begin
    unique case (cmd_i.addr)
      ktt_pkg::A_LAST: raddr = last_idx;
      ktt_pkg::A_FP:   raddr = fp_q;
      ktt_pkg::A_FPM1: raddr = fp_q - FW'(1);
      default:         raddr = '0;
    endcase
  end

  ktt_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (MAX_FRAMES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_ext[FW-1:0]),
    .wdata_i (endt_ext[TIME_BITS-1:0]),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // comparisons against table data
  logic signed [AW:0] anim_s, rd_s, lo_s, num_s, den_ext;
  logic signed [TIME_BITS:0] den_s;
  logic gt_rd;

  assign anim_s  = {anim_q[AW-1], anim_q};
  assign rd_s    = $signed({{(AW+1-TIME_BITS){1'b0}}, rdata});
  assign lo_s    = $signed({{(AW+1-TIME_BITS){1'b0}}, lo_q});
  assign gt_rd   = anim_s > rd_s;
  assign num_s   = anim_s - lo_s;
  assign den_s   = $signed({1'b0, hi_q}) - $signed({1'b0, lo_q});
  assign den_ext = (AW+1)'(den_s);

  // saturating advance
  logic signed [SUMW-1:0] sum_s;
  logic signed [AW-1:0]   anim_sat;
  logic d_pos, d_neg;

  always_comb begin
    sum_s = SUMW'(anim_q) + SUMW'(delta_q);
    if (sum_s > SUMW'(ANIM_MAX)) begin
      anim_sat = ANIM_MAX;
    end else if (sum_s < SUMW'(ANIM_MIN)) begin
      anim_sat = ANIM_MIN;
    end else begin
      anim_sat = $signed(sum_s[AW-1:0]);
    end
  end

  assign d_pos = !delta_q[ktt_pkg::DELTA_W-1] && (delta_q != '0);
  assign d_neg = delta_q[ktt_pkg::DELTA_W-1];

  // shared divider: wrap count or progress fraction
  logic          div_start, div_busy;
  logic [DW-1:0] dvd, quo, anim_dw;
  logic [TIME_BITS-1:0] dvs, rem;

  assign anim_dw   = DW'(anim_q);
  assign div_start = (cmd_i.op == ktt_pkg::OP_DIV_WRAP) || (cmd_i.op == ktt_pkg::OP_DIV_PROG);

  always_comb begin
    if (cmd_i.op == ktt_pkg::OP_DIV_PROG) begin
      dvd = {num_s[TIME_BITS-1:0], {ktt_pkg::PROG_W{1'b0}}};
      dvs = den_s[TIME_BITS-1:0];
    end else if (back_q) begin
      dvd = DW'(0) - anim_dw + DW'(rdata) - DW'(1);
      dvs = rdata;
    end else begin
      dvd = anim_dw - DW'(1);
      dvs = rdata;
    end
  end

  ktt_div #(
    .DW (DW),
    .VW (TIME_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (dvd),
    .dvs_i   (dvs),
    .busy_o  (div_busy),
    .quo_o   (quo),
    .rem_o   (rem)
  );

  // play counting after a wrap
  logic [DW:0] play_sum;
  logic        hit_fwd, hit_bwd;

  assign play_sum = (DW+1)'(plays_q) + (DW+1)'(quo);
  assign hit_fwd  = !endless_q && (play_sum >= (DW+1)'(target_q));
  assign hit_bwd  = !endless_q && (quo >= DW'(plays_q));

  // next state of the timeline
  always_comb begin
    anim_d      = anim_q;
    fp_d        = fp_q;
    plays_d     = plays_q;
    endless_d   = endless_q;
    back_d      = back_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (cmd_i.op)
      ktt_pkg::OP_ACCEPT: begin
        if (fp_q > last_idx) begin
          fp_d = last_idx;
        end
      end
      ktt_pkg::OP_EXEC: begin
        case (req_q)
          ktt_pkg::REQ_ADVANCE: begin
            anim_d = anim_sat;
            if (d_pos) begin
              back_d = 1'b0;
            end else if (d_neg) begin
              back_d = 1'b1;
            end
          end
          ktt_pkg::REQ_RESTART: begin
            plays_d   = spc_q;
            endless_d = loop_q;
            anim_d    = '0;
            fp_d      = '0;
            back_d    = 1'b0;
          end
          default: begin
          end
        endcase
      end
      ktt_pkg::OP_APPLY_WRAP: begin
        if (back_q) begin
          if (hit_bwd) begin
            plays_d = '0;
            fp_d    = '0;
            anim_d  = '0;
          end else begin
            if (!endless_q) begin
              plays_d = plays_q - quo[PW-1:0];
            end
            anim_d = $signed(AW'(last_q) - AW'(rem) - AW'(1));
            fp_d   = last_idx;
          end
        end else begin
          if (hit_fwd) begin
            plays_d = target_q;
            fp_d    = last_idx;
            anim_d  = $signed(AW'(last_q));
          end else begin
            if (!endless_q) begin
              plays_d = play_sum[PW-1:0];
            end
            anim_d = $signed(AW'(rem) + AW'(1));
            fp_d   = '0;
          end
        end
      end
      ktt_pkg::OP_FP_INC:  fp_d = fp_q + FW'(1);
      ktt_pkg::OP_FP_DEC:  fp_d = fp_q - FW'(1);
      ktt_pkg::OP_FP_ZERO: fp_d = '0;
      ktt_pkg::OP_OUT:     out_valid_d = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcount_q    <= ktt_pkg::FCNT_W'(1);
      target_q    <= PW'(1);
      anim_q      <= '0;
      fp_q        <= '0;
      plays_q     <= '0;
      endless_q   <= 1'b0;
      back_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (ktt_pkg::cfg_reg_e'(cfg_idx_i))
          ktt_pkg::CFG_FRAME_COUNT: fcount_q <= cfg_data_i[ktt_pkg::FCNT_W-1:0];
          ktt_pkg::CFG_PLAY_TARGET: target_q <= cfg_data_i[PW-1:0];
          default: begin
          end
        endcase
      end
      anim_q      <= anim_d;
      fp_q        <= fp_d;
      plays_q     <= plays_d;
      endless_q   <= endless_d;
      back_q      <= back_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  logic [IXW-1:0] fp_ext;
  assign fp_ext = IXW'(fp_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == ktt_pkg::OP_ACCEPT) begin
      req_q   <= ktt_pkg::req_e'(req_type_i);
      idx_q   <= frame_index_i;
      endt_q  <= frame_end_time_i;
      delta_q <= time_delta_i;
      spc_q   <= start_play_count_i;
      loop_q  <= loop_forever_i;
    end
    if (cmd_i.op == ktt_pkg::OP_DIV_WRAP) begin
      last_q <= rdata;
    end
    if (cmd_i.op == ktt_pkg::OP_CAP_HI) begin
      hi_q <= rdata;
      lo_q <= '0;
    end
    if (cmd_i.op == ktt_pkg::OP_CAP_LO) begin
      lo_q <= rdata;
    end
    case (cmd_i.op)
      ktt_pkg::OP_PROG_ZERO: prog_q <= '0;
      ktt_pkg::OP_PROG_SAT:  prog_q <= '1;
      ktt_pkg::OP_PROG_Q:    prog_q <= (|quo[DW-1:ktt_pkg::PROG_W]) ? '1 :
                                       quo[ktt_pkg::PROG_W-1:0];
      default: begin
      end
    endcase
    if (cmd_i.op == ktt_pkg::OP_OUT) begin
      out_frame_q <= fp_ext[ktt_pkg::IDX_W-1:0];
      out_plays_q <= plays_q;
      out_prog_q  <= prog_q;
      out_fin_q   <= !endless_q && (back_q ? (plays_q == '0) : (plays_q == target_q));
    end
  end

  // status to the sequencer
  always_comb begin
    st_o.in_valid   = in_valid_i;
    st_o.req        = req_q;
    st_o.go_move    = (d_pos && (endless_q || plays_q != target_q)) ||
                      (d_neg && (endless_q || plays_q != '0));
    st_o.rd_zero    = (rdata == '0);
    st_o.wrap       = back_q ? anim_q[AW-1] : gt_rd;
    st_o.div_busy   = div_busy;
    st_o.hit_end    = back_q ? hit_bwd : hit_fwd;
    st_o.back       = back_q;
    st_o.gt_rd      = gt_rd;
    st_o.fp_lt_last = fp_q < last_idx;
    st_o.fp_zero    = (fp_q == '0);
    st_o.num_le0    = num_s[AW] || (num_s == '0);
    st_o.prog_sat   = den_s[TIME_BITS] || (den_s == '0) || (num_s >= den_ext);
    st_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o      = out_valid_q;
  assign current_frame_o  = out_frame_q;
  assign play_count_o     = out_plays_q;
  assign frame_progress_o = out_prog_q;
  assign finished_o       = out_fin_q;
endmodule

// ===== src/keyframe_timeline_tracker.sv =====
// keyframe animation timeline tracker, top level
// each transaction is accepted, dispatched, then runs the progress steps (last end
// time read, frame end reads and, unless zero or saturated, the progress division)
// before the result; advance items that move first read the last end time and then
// run a wrap division if needed and a frame search; one transaction in work at a time
// reset clears timeline state and registers (frame_count 1, play_target 1); table is unset
module keyframe_timeline_tracker #(
  parameter int MAX_FRAMES = ktt_pkg::DEF_MAX_FRAMES,
  parameter int TIME_BITS  = ktt_pkg::DEF_TIME_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ktt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ktt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ktt_in_if.sink                         in_i,
  ktt_out_if.source                      out_o
);
  // command and status between sequencer and datapath
  ktt_pkg::cmd_t    cmd;
  ktt_pkg::status_t st;

  // sequencer: walks wrap, frame search and progress steps per transaction
  ktt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .st_i       (st),
    .cmd_o      (cmd),
    .in_ready_o (in_i.ready)
  );

  // datapath: table ram, shared divider and result register
  ktt_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_i.valid),
    .req_type_i         (in_i.req_type),
    .frame_index_i      (in_i.frame_index),
    .frame_end_time_i   (in_i.frame_end_time),
    .time_delta_i       (in_i.time_delta),
    .start_play_count_i (in_i.start_play_count),
    .loop_forever_i     (in_i.loop_forever),
    .out_valid_o        (out_o.valid),
    .out_ready_i        (out_o.ready),
    .current_frame_o    (out_o.current_frame),
    .play_count_o       (out_o.play_count),
    .frame_progress_o   (out_o.frame_progress),
    .finished_o         (out_o.finished),
    .cmd_i              (cmd),
    .st_o               (st)
  );
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the keyframe timeline tracker
module tb;
  import ktt_pkg::*;

  localparam int NFRAMES    = DEF_MAX_FRAMES;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    req_e                      req;
    logic [IDX_W-1:0]          idx;
    logic [END_W-1:0]          end_t;
    logic signed [DELTA_W-1:0] delta;
    logic [PLAY_W-1:0]         start_cnt;
    logic                      endless;
  } tl_req_t;

  typedef struct {
    logic [IDX_W-1:0]  frame;
    logic [PLAY_W-1:0] plays;
    logic [PROG_W-1:0] prog;
    logic              fin;
  } tl_status_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  ktt_in_if  in_ch ();
  ktt_out_if out_ch ();

  keyframe_timeline_tracker u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  tl_req_t    pending_req[$];
  tl_status_t expected_status[$];
  tl_req_t    drv_req;
  int         mismatches = 0;
  int         src_idle = 0;
  int         snk_stall = 0;
  int         idle_cycles = 0;

  // timeline model state, mirrors the block
  longint      tl_end[NFRAMES];
  longint      anim;
  int unsigned pos;
  longint      plays;
  bit          endless_on;
  bit          went_back;
  int unsigned fcnt_reg = 1;
  longint      target_reg = 1;

  function automatic longint sat_anim(longint v);
    longint hi;
    hi = (64'sd1 <<< 39) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint tab(int unsigned i);
    return tl_end[i % NFRAMES];
  endfunction

  function automatic void play_forward(int unsigned cnt);
    longint last, n, sum;
    last = tab(cnt - 1);
    if (last <= 0) return;
    if (anim > last) begin
      n = (anim - 1) / last;
      anim -= n * last;
      if (!endless_on) begin
        sum = plays + n;
        // target reached: hold on the last frame
        if (sum >= target_reg) begin
          plays = target_reg;
          pos = cnt - 1;
          anim = last;
          return;
        end
        plays = sum;
      end
      pos = 0;
    end
    while (pos < cnt - 1 && anim > tab(pos)) pos++;
  endfunction

  function automatic void play_backward(int unsigned cnt);
    longint last, n;
    last = tab(cnt - 1);
    if (last <= 0) return;
    if (anim < 0) begin
      n = (-anim + last - 1) / last;
      anim += n * last;
      if (!endless_on) begin
        // count exhausted: hold on frame 0
        if (n >= plays) begin
          plays = 0;
          pos = 0;
          anim = 0;
          return;
        end
        plays -= n;
      end
      pos = cnt - 1;
    end
    if (anim > tab(0)) begin
      while (pos > 0 && anim <= tab(pos - 1)) pos--;
    end else begin
      pos = 0;
    end
  endfunction

  function automatic logic [PROG_W-1:0] frame_fraction(int unsigned cnt);
    longint num, den, q;
    if (tab(cnt - 1) <= 0) return '0;
    if (pos != 0) begin
      num = anim - tab(pos - 1);
      den = tab(pos) - tab(pos - 1);
    end else begin
      num = anim;
      den = tab(0);
    end
    if (num <= 0) return '0;
    if (den <= 0 || num >= den) return 16'hFFFF;
    q = (num <<< 16) / den;
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  // advance the timeline model by one request and queue the status it yields
  function automatic void predict_status(tl_req_t r);
    int unsigned cnt;
    tl_status_t  st;
    longint      d;
    cnt = (fcnt_reg < 1) ? 1 : (fcnt_reg > NFRAMES) ? NFRAMES : fcnt_reg;
    if (pos > cnt - 1) pos = cnt - 1;
    case (r.req)
      REQ_LOAD: begin
        tl_end[r.idx] = longint'(r.end_t);
      end
      REQ_ADVANCE: begin
        d = longint'(r.delta);
        anim = sat_anim(anim + d);
        if (d > 0) begin
          went_back = 1'b0;
          if (endless_on || plays != target_reg) play_forward(cnt);
        end else if (d < 0) begin
          went_back = 1'b1;
          if (endless_on || plays != 0) play_backward(cnt);
        end
      end
      REQ_RESTART: begin
        plays = longint'(r.start_cnt);
        endless_on = r.endless;
        anim = 0;
        pos = 0;
        went_back = 1'b0;
      end
      default: ;
    endcase
    st.frame = pos[IDX_W-1:0];
    st.plays = plays[PLAY_W-1:0];
    st.prog  = frame_fraction(cnt);
    st.fin   = endless_on ? 1'b0 : went_back ? (plays == 0) : (plays == target_reg);
    expected_status.push_back(st);
  endfunction

  // sender: next request from the pending queue
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_status(drv_req);
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_req.size() > 0 && $urandom_range(99) >= src_idle) begin
          drv_req = pending_req.pop_front();
          in_ch.valid            <= 1'b1;
          in_ch.req_type         <= drv_req.req;
          in_ch.frame_index      <= drv_req.idx;
          in_ch.frame_end_time   <= drv_req.end_t;
          in_ch.time_delta       <= drv_req.delta;
          in_ch.start_play_count <= drv_req.start_cnt;
          in_ch.loop_forever     <= drv_req.endless;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stall, compare each status transaction with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    tl_status_t exp_st;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_status.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected status transaction: frame %0d plays %0d",
                                         out_ch.current_frame, out_ch.play_count);
        end else begin
          exp_st = expected_status.pop_front();
          if (out_ch.current_frame !== exp_st.frame || out_ch.play_count !== exp_st.plays ||
              out_ch.frame_progress !== exp_st.prog || out_ch.finished !== exp_st.fin) begin
            mismatches++;
            if (mismatches <= 10)
              $display("status mismatch: exp frame %0d plays %0d prog %0d fin %0b, got %0d %0d %0d %0b",
                       exp_st.frame, exp_st.plays, exp_st.prog, exp_st.fin,
                       out_ch.current_frame, out_ch.play_count, out_ch.frame_progress,
                       out_ch.finished);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= snk_stall);
    end
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("** keyframe_timeline_tracker: FAILED **");
        $finish;
      end
    end
  end

  function automatic void push_load(int unsigned i, logic [END_W-1:0] t);
    tl_req_t r;
    r = '{REQ_LOAD, i[IDX_W-1:0], t, $urandom(), PLAY_W'($urandom()),
          1'($urandom_range(1))};
    pending_req.push_back(r);
  endfunction

  function automatic void push_advance(logic signed [DELTA_W-1:0] d);
    tl_req_t r;
    r = '{REQ_ADVANCE, IDX_W'($urandom()), $urandom(), d, PLAY_W'($urandom()),
          1'($urandom_range(1))};
    pending_req.push_back(r);
  endfunction

  function automatic void push_restart(logic [PLAY_W-1:0] c, logic lf);
    tl_req_t r;
    r = '{REQ_RESTART, IDX_W'($urandom()), $urandom(), $urandom(), c, lf};
    pending_req.push_back(r);
  endfunction

  function automatic void push_nop();
    tl_req_t r;
    r = '{REQ_NOP, IDX_W'($urandom()), $urandom(), $urandom(), PLAY_W'($urandom()),
          1'($urandom_range(1))};
    pending_req.push_back(r);
  endfunction

  // load a monotonic table of cumulative end times
  function automatic void fill_timeline(int unsigned step_max);
    longint t;
    t = 0;
    for (int i = 0; i < NFRAMES; i++) begin
      t += $urandom_range(step_max, 1);
      push_load(i, t[END_W-1:0]);
    end
  endfunction

  function automatic void push_random(int unsigned n);
    int unsigned sel, sh;
    logic signed [DELTA_W-1:0] d;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      if (sel < 80) begin
        sh = $urandom_range(24, 6);
        d = $urandom_range((1 << sh), 1);
        if (sel < 4) d = $urandom();
        else if ($urandom_range(99) < 30) d = -d;
        push_advance(d);
      end else if (sel < 90) begin
        push_restart(PLAY_W'(($urandom_range(9) == 0) ? $urandom() : $urandom_range(6)),
                     $urandom_range(3) == 0);
      end else if (sel < 97) begin
        // reload one entry, occasionally with an arbitrary value
        push_load($urandom_range(NFRAMES - 1),
                  ($urandom_range(3) == 0) ? $urandom() : $urandom_range(32'h0080_0000));
      end else begin
        push_nop();
      end
    end
  endfunction

  // sampled at the falling edge so that values driven at the rising edge have settled
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_req.size() != 0 || in_ch.valid || expected_status.size() != 0);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [CFG_DATA_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= r;
    cfg_data_i <= v;
    if (r == CFG_FRAME_COUNT) fcnt_reg = v & 16'h7F;
    else target_reg = longint'(v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  int unsigned ph_fcnt[6]   = '{1, 64, 8, 127, 0, 3};
  int unsigned ph_target[6] = '{1, 5, 0, 65535, 2, 1};
  int          ph_src[6]    = '{0, 0, 88, 0, 38, 0};
  int          ph_snk[6]    = '{0, 0, 0, 88, 38, 0};

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = '0;
    in_ch.frame_index = '0;
    in_ch.frame_end_time = '0;
    in_ch.time_delta = '0;
    in_ch.start_play_count = '0;
    in_ch.loop_forever = 1'b0;
    out_ch.ready = 1'b0;
    anim = 0; pos = 0; plays = 0; endless_on = 0; went_back = 0;
    foreach (tl_end[i]) tl_end[i] = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero timeline, delta extremes, endless and counted wraps
    push_load(0, 32'h0);
    push_advance(32'sd1);
    push_advance(-32'sd5);
    push_advance(32'sd0);
    push_nop();
    push_restart(16'd0, 1'b0);
    push_advance(-32'sd1);
    push_load(0, 32'hFFFF_FFFF);
    push_advance(32'sh7FFF_FFFF);
    push_advance(32'sh7FFF_FFFF);
    push_advance(32'sh8000_0000);
    push_restart(16'hFFFF, 1'b1);
    push_advance(32'sh7FFF_FFFF);
    push_advance(32'sh7FFF_FFFF);
    push_advance(32'sh7FFF_FFFF);
    push_advance(32'sh8000_0000);
    push_load(0, 32'h0001_0000);
    push_restart(16'd3, 1'b0);
    push_advance(-32'sh0003_8000);
    push_advance(32'sh0000_8000);
    push_advance(32'sh0010_0000);
    push_advance(32'sh0000_4000);
    push_advance(-32'sh0000_4000);
    fill_timeline(32'h0002_0000);

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      if (p > 0) begin
        write_reg(CFG_FRAME_COUNT, CFG_DATA_W'(ph_fcnt[p]));
        write_reg(CFG_PLAY_TARGET, CFG_DATA_W'(ph_target[p]));
      end
      src_idle  = ph_src[p];
      snk_stall = ph_snk[p];
      if (p == 2) fill_timeline(32'h0000_0400);
      if (p == 3) fill_timeline(32'h0004_0000);
      push_restart(16'd0, 1'b0);
      push_random(260);
    end
    wait_drained();
    repeat (300) @(posedge clk_i);

    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("** keyframe_timeline_tracker: PASSED **");
    end else begin
      $display("** keyframe_timeline_tracker: FAILED **");
    end
    $finish;
  end
endmodule
